[rtl/swlf_pkg.sv]
// ----------------------------------------------------------------------------
// swlf_pkg
// Shared types and constants for the sliding window line fit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swlf_pkg;

    localparam int DEPTH       = 8;       // window points
    localparam int NSTG        = 8;       // fit stages after the window
    localparam int SLOPE_W     = 18;
    localparam int ICEPT_W     = 34;
    localparam int OUT_FIELD_W = 2 * SLOPE_W + 2 * ICEPT_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int    SLOPE_DIV = 21;                 // 84 / 4, after the Q8 shift
    localparam int    T_OFS2    = 9;                  // 2 * 4.5
    localparam int    SLOPE_LIM = 100000;
    localparam longint ICEPT_LIM = 64'sd8589934591;

    typedef logic [2:0] t_dir;

    localparam t_dir DIR_FLAT     = 3'd0;
    localparam t_dir DIR_UP_RIGHT = 3'd1;
    localparam t_dir DIR_UP_LEFT  = 3'd2;
    localparam t_dir DIR_DN_LEFT  = 3'd3;
    localparam t_dir DIR_DN_RIGHT = 3'd4;

endpackage

`default_nettype wire

[rtl/swlf_cell.sv]
// ----------------------------------------------------------------------------
// swlf_cell
// One window point: holds (x, y), shifts to the older neighbor, gives its
// weighted terms and the direction of the step from it to the newer point.
// ----------------------------------------------------------------------------
`default_nettype none

module swlf_cell #(
    parameter int W = 11,
    parameter int K = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic [W-1:0]         i_x,
    input  logic [W-1:0]         i_y,
    output logic [W-1:0]         o_x,
    output logic [W-1:0]         o_y,
    output logic signed [W+3:0]  o_term_x,
    output logic signed [W+3:0]  o_term_y,
    output swlf_pkg::t_dir       o_dir
);
    import swlf_pkg::*;

    logic [W-1:0] r_x;
    logic [W-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_shift) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

    assign o_term_x = (W+4)'(K) * (W+4)'($signed({1'b0, r_x}));
    assign o_term_y = (W+4)'(K) * (W+4)'($signed({1'b0, r_y}));

    // step from this (older) point to the newer neighbor on i_x / i_y
    always_comb begin
        if (i_x > r_x && i_y > r_y) begin
            o_dir = DIR_UP_RIGHT;
        end else if (i_x < r_x && i_y > r_y) begin
            o_dir = DIR_UP_LEFT;
        end else if (i_x < r_x && i_y < r_y) begin
            o_dir = DIR_DN_LEFT;
        end else if (i_x > r_x && i_y < r_y) begin
            o_dir = DIR_DN_RIGHT;
        end else begin
            o_dir = DIR_FLAT;
        end
    end

endmodule

`default_nettype wire

[rtl/swlf_fit.sv]
// ----------------------------------------------------------------------------
// swlf_fit
// Per-axis fit pipeline: weighted sum, slope by reciprocal multiply,
// saturation, intercept multiply, halving and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module swlf_fit #(
    parameter int W  = 11,
    parameter int CB = 16
) (
    input  logic                                 i_clk,
    input  logic [swlf_pkg::NSTG:1]              i_ld,
    input  logic signed [W+3:0]                  i_term [swlf_pkg::DEPTH],
    input  logic [W-1:0]                         i_val  [swlf_pkg::DEPTH],
    input  logic [CB-1:0]                        i_cnt,
    output logic signed [swlf_pkg::SLOPE_W-1:0]  o_slope,
    output logic signed [swlf_pkg::ICEPT_W-1:0]  o_icept
);
    import swlf_pkg::*;

    localparam int SW = W + 6;
    localparam int NB = W + 10;
    localparam int QB = NB - 4;
    localparam int PB = 2 * NB - 4;
    localparam int TB = CB + 2;
    localparam int PW = SLOPE_W + TB + 1;
    localparam int DW = PW + 1;
    localparam logic [QB-1:0] MF = QB'((64'd1 << NB) / SLOPE_DIV);

    // stage 1: sums
    logic signed [SW-1:0] ws;
    logic [W+2:0]         sm;
    logic signed [SW-1:0] r_wsum1;
    logic [W-1:0]         r_avg1, r_avg2, r_avg3, r_avg4, r_avg5, r_avg6;
    logic [CB-1:0]        r_cnt1, r_cnt2, r_cnt3, r_cnt4, r_cnt5;

    always_comb begin
        ws = '0;
        sm = '0;
        for (int i = 0; i < DEPTH; i++) begin
            ws = ws + SW'(i_term[i]);
            sm = sm + (W+3)'(i_val[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_wsum1 <= ws;
            r_avg1  <= sm[W+2:3];
            r_cnt1  <= i_cnt;
        end
    end

    // stage 2: magnitude scaled by 64
    logic signed [SW-1:0] magw;
    logic [NB-1:0]        r_mag2, r_mag3;
    logic                 r_neg2, r_neg3, r_neg4;

    assign magw = r_wsum1[SW-1] ? -r_wsum1 : r_wsum1;

    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r_mag2 <= {magw[W+3:0], 6'b0};
            r_neg2 <= r_wsum1[SW-1];
            r_avg2 <= r_avg1;
            r_cnt2 <= r_cnt1;
        end
    end

    // stage 3: reciprocal multiply
    logic [PB-1:0] r_prod3;

    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r_prod3 <= PB'(r_mag2) * PB'(MF);
            r_mag3  <= r_mag2;
            r_neg3  <= r_neg2;
            r_avg3  <= r_avg2;
            r_cnt3  <= r_cnt2;
        end
    end

    // stage 4: quotient estimate is low by at most one
    logic [QB-1:0] q0;
    logic [NB-1:0] t21;
    logic [NB-1:0] rem;
    logic [QB-1:0] r_q4;

    assign q0  = r_prod3[PB-1:NB];
    assign t21 = NB'({q0, 4'b0}) + NB'({q0, 2'b0}) + NB'(q0);
    assign rem = r_mag3 - t21;

    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r_q4   <= (rem >= NB'(SLOPE_DIV)) ? q0 + QB'(1) : q0;
            r_neg4 <= r_neg3;
            r_avg4 <= r_avg3;
            r_cnt4 <= r_cnt3;
        end
    end

    // stage 5: saturate and sign
    logic [63:0]                qx;
    logic [16:0]                qc;
    logic signed [SLOPE_W-1:0]  qs;
    logic signed [SLOPE_W-1:0]  r_slope5, r_slope6, r_slope7, r_slope8;

    assign qx = 64'(r_q4);
    assign qc = (qx > 64'(SLOPE_LIM)) ? 17'(SLOPE_LIM) : qx[16:0];
    assign qs = {1'b0, qc};

    always_ff @(posedge i_clk) begin
        if (i_ld[5]) begin
            r_slope5 <= r_neg4 ? -qs : qs;
            r_avg5   <= r_avg4;
            r_cnt5   <= r_cnt4;
        end
    end

    // stage 6: slope * (2 * count + 9)
    logic [TB-1:0]        t2;
    logic signed [PW-1:0] r_p6;

    assign t2 = TB'({r_cnt5, 1'b0}) + TB'(T_OFS2);

    always_ff @(posedge i_clk) begin
        if (i_ld[6]) begin
            r_p6     <= PW'(r_slope5) * PW'($signed({1'b0, t2}));
            r_slope6 <= r_slope5;
            r_avg6   <= r_avg5;
        end
    end

    // stage 7: 512 * avg - product
    logic signed [DW-1:0] r_d7;

    always_ff @(posedge i_clk) begin
        if (i_ld[7]) begin
            r_d7     <= DW'($signed({1'b0, r_avg6, 9'b0})) - DW'(r_p6);
            r_slope7 <= r_slope6;
        end
    end

    // stage 8: halve toward zero, saturate
    logic signed [DW-1:0]      dr;
    logic signed [DW-1:0]      h;
    logic signed [63:0]        hx;
    logic signed [ICEPT_W-1:0] r_icept8;

    assign dr = r_d7 + DW'(r_d7[DW-1]);
    assign h  = dr >>> 1;
    assign hx = 64'(h);

    always_ff @(posedge i_clk) begin
        if (i_ld[8]) begin
            if (hx > ICEPT_LIM) begin
                r_icept8 <= ICEPT_W'(ICEPT_LIM);
            end else if (hx < -ICEPT_LIM) begin
                r_icept8 <= ICEPT_W'(-ICEPT_LIM);
            end else begin
                r_icept8 <= hx[ICEPT_W-1:0];
            end
            r_slope8 <= r_slope7;
        end
    end

    assign o_slope = r_slope8;
    assign o_icept = r_icept8;

endmodule

`default_nettype wire

[rtl/sliding_window_line_fit_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_line_fit_unit
// Eight-point sliding window least-squares line fit for x and y against
// sample time, with a strict diagonal monotonic flag.
// ----------------------------------------------------------------------------
// Path from input beat to output beat valid: the window cell row, then an
//   8-stage fit pipeline per axis.
// Throughput: one beat per cycle; each stage holds only while the one after
//   it is full and stalled, so input stays ready while results wait until
//   the window and all eight fit stages hold a beat.
// Reset: clears the window to zeros, the sample count and all stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_line_fit_unit #(
    parameter int COORD_BITS = 11,
    parameter int COUNT_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // new_x, new_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]        i_s_tdata,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // slope_x, slope_y, icept_x, icept_y, monotonic
    output logic [swlf_pkg::OUT_TDATA_W-1:0]         o_m_tdata
);
    import swlf_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int PAD = OUT_TDATA_W - OUT_FIELD_W;

    logic [NSTG:0] ld;
    logic [NSTG:0] r_vld;
    logic          accept;

    always_comb begin
        ld[NSTG] = !r_vld[NSTG] || i_m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_s_tready = ld[0];
    assign accept     = i_s_tvalid && ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k <= NSTG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // sample count: the window beat carries the count before increment
    logic [COUNT_BITS-1:0] r_fit_cnt;
    logic [COUNT_BITS-1:0] r_cnt0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_cnt <= '0;
            r_cnt0    <= '0;
        end else if (accept) begin
            r_cnt0 <= r_fit_cnt;
            if (r_fit_cnt != '1) begin
                r_fit_cnt <= r_fit_cnt + COUNT_BITS'(1);
            end
        end
    end

    // window cell row, cell 0 newest
    logic [W-1:0]        cx     [DEPTH];
    logic [W-1:0]        cy     [DEPTH];
    logic signed [W+3:0] term_x [DEPTH];
    logic signed [W+3:0] term_y [DEPTH];
    t_dir                dir    [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [W-1:0] nx;
        logic [W-1:0] ny;
        if (g == 0) begin : g_head
            assign nx = i_s_tdata[W-1:0];
            assign ny = i_s_tdata[2*W-1:W];
        end else begin : g_body
            assign nx = cx[g-1];
            assign ny = cy[g-1];
        end
        swlf_cell #(
            .W (W),
            .K (7 - 2 * g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (accept),
            .i_x      (nx),
            .i_y      (ny),
            .o_x      (cx[g]),
            .o_y      (cy[g]),
            .o_term_x (term_x[g]),
            .o_term_y (term_y[g]),
            .o_dir    (dir[g])
        );
    end

    // monotonic: step of cell 1 sets the direction, all others must match
    logic              mono;
    logic [NSTG:1]     r_mono;

    always_comb begin
        mono = (dir[1] != DIR_FLAT);
        for (int k = 2; k < DEPTH; k++) begin
            if (dir[k] != dir[1]) begin
                mono = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_mono[1] <= mono;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (ld[k]) begin
                r_mono[k] <= r_mono[k-1];
            end
        end
    end

    logic signed [SLOPE_W-1:0] slope_x, slope_y;
    logic signed [ICEPT_W-1:0] icept_x, icept_y;

    swlf_fit #(
        .W  (W),
        .CB (COUNT_BITS)
    ) u_fit_x (
        .i_clk   (i_clk),
        .i_ld    (ld[NSTG:1]),
        .i_term  (term_x),
        .i_val   (cx),
        .i_cnt   (r_cnt0),
        .o_slope (slope_x),
        .o_icept (icept_x)
    );

    swlf_fit #(
        .W  (W),
        .CB (COUNT_BITS)
    ) u_fit_y (
        .i_clk   (i_clk),
        .i_ld    (ld[NSTG:1]),
        .i_term  (term_y),
        .i_val   (cy),
        .i_cnt   (r_cnt0),
        .o_slope (slope_y),
        .o_icept (icept_y)
    );

    assign o_m_tvalid = r_vld[NSTG];
    assign o_m_tdata  = {{PAD{1'b0}}, r_mono[NSTG], icept_y, icept_x, slope_y, slope_x};

endmodule

`default_nettype wire

[bench/tb_sliding_window_line_fit_unit.sv]
// ----------------------------------------------------------------------------
// tb_sliding_window_line_fit_unit
// Self-checking bench for the sliding window line fit unit. A queue-fed
// driver streams points in with random gaps, a monitor takes fit results
// under random backpressure and checks every field against a predictor of
// the 8-point window. Phases: directed edge points, random tracks and noise,
// a back-to-back stream with no idles on either side, then a random tail.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sliding_window_line_fit_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import swlf_pkg::*;

    localparam int COORD_BITS = 11;
    localparam int COUNT_BITS = 16;
    localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int CMAX       = (1 << COORD_BITS) - 1;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 24;

    // result field offsets in o_m_tdata
    localparam int SX_LO = 0;
    localparam int SY_LO = SLOPE_W;
    localparam int IX_LO = 2 * SLOPE_W;
    localparam int IY_LO = 2 * SLOPE_W + ICEPT_W;
    localparam int MONO_BIT = 2 * SLOPE_W + 2 * ICEPT_W;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_point;

    typedef struct {
        logic [SLOPE_W-1:0] slope_x;
        logic [SLOPE_W-1:0] slope_y;
        logic [ICEPT_W-1:0] icept_x;
        logic [ICEPT_W-1:0] icept_y;
        logic               mono;
    } t_fit_rec;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_W-1:0]        i_s_tdata = '0;  // new_x, new_y
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;       // slope_x, slope_y, icept_x, icept_y, monotonic

    sliding_window_line_fit_unit #(
        .COORD_BITS(COORD_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // predictor state
    logic [COORD_BITS-1:0] win [2][DEPTH];
    logic [COUNT_BITS-1:0] fit_cnt;

    t_point   points_todo [$];
    t_fit_rec fits_due [$];

    int  err_count = 0;
    int  cycles = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;
    bit  steady = 1'b0;
    t_point last_pt;

    function automatic longint clamp_lim(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_dir step_dir(input logic [COORD_BITS-1:0] nx, ny, ox, oy);
        if (nx > ox && ny > oy) return DIR_UP_RIGHT;
        if (nx < ox && ny > oy) return DIR_UP_LEFT;
        if (nx < ox && ny < oy) return DIR_DN_LEFT;
        if (nx > ox && ny < oy) return DIR_DN_RIGHT;
        return DIR_FLAT;
    endfunction

    // shift one point in, fit both axes at the current count, then bump it
    function automatic t_fit_rec predict_fit(input logic [COORD_BITS-1:0] nx, ny);
        t_fit_rec r;
        longint   slope [2];
        longint   icept [2];
        longint   wsum, total, avg, t2;
        t_dir     d0;
        logic     mono;
        int       a, i;
        for (i = DEPTH - 1; i > 0; i--) begin
            win[0][i] = win[0][i-1];
            win[1][i] = win[1][i-1];
        end
        win[0][0] = nx;
        win[1][0] = ny;
        t2 = 2 * longint'(fit_cnt) + T_OFS2;
        for (a = 0; a < 2; a++) begin
            wsum = 0;
            total = 0;
            for (i = 0; i < DEPTH; i++) begin
                // index 0 is newest, weight +7
                wsum += (7 - 2 * i) * longint'(win[a][i]);
                total += longint'(win[a][i]);
            end
            avg = total / 8;
            slope[a] = clamp_lim((wsum * 256) / 84, SLOPE_LIM);
            icept[a] = clamp_lim((avg * 512 - slope[a] * t2) / 2, ICEPT_LIM);
        end
        d0 = step_dir(win[0][0], win[1][0], win[0][1], win[1][1]);
        mono = (d0 != DIR_FLAT);
        for (i = 1; i < DEPTH - 1; i++) begin
            if (step_dir(win[0][i], win[1][i], win[0][i+1], win[1][i+1]) != d0)
                mono = 1'b0;
        end
        if (fit_cnt != {COUNT_BITS{1'b1}})
            fit_cnt = fit_cnt + 1'b1;
        r.slope_x = slope[0][SLOPE_W-1:0];
        r.slope_y = slope[1][SLOPE_W-1:0];
        r.icept_x = icept[0][ICEPT_W-1:0];
        r.icept_y = icept[1][ICEPT_W-1:0];
        r.mono    = mono;
        return r;
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_point(input int x, input int y);
        t_point p;
        p.x = x[COORD_BITS-1:0];
        p.y = y[COORD_BITS-1:0];
        points_todo.push_back(p);
        last_pt = p;
    endtask

    // straight diagonal track with random step sizes; a broken one has one
    // step flattened or turned back on one axis
    task automatic push_track(input bit broken);
        int L, mx, sx, sy, x, y, bad, j, dx, dy, dir;
        dir = $urandom_range(0, 3);
        sx = (dir == 0 || dir == 3) ? 1 : -1;
        sy = (dir == 0 || dir == 1) ? 1 : -1;
        L = $urandom_range(8, 16);
        mx = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, CMAX / L);
        x = (sx > 0) ? $urandom_range(0, CMAX - mx * (L - 1)) : $urandom_range(mx * (L - 1), CMAX);
        y = (sy > 0) ? $urandom_range(0, CMAX - mx * (L - 1)) : $urandom_range(mx * (L - 1), CMAX);
        bad = broken ? $urandom_range(1, L - 1) : -1;
        push_point(x, y);
        for (j = 1; j < L; j++) begin
            dx = sx * $urandom_range(1, mx);
            dy = sy * $urandom_range(1, mx);
            if (j == bad) begin
                case ($urandom_range(0, 3))
                    0: dx = 0;
                    1: dy = 0;
                    2: dx = -dx;
                    default: dy = -dy;
                endcase
            end
            x = x + dx;
            y = y + dy;
            if (x < 0) x = 0;
            if (x > CMAX) x = CMAX;
            if (y < 0) y = 0;
            if (y > CMAX) y = CMAX;
            push_point(x, y);
        end
    endtask

    task automatic queue_random(input int n);
        int start, r;
        start = points_todo.size();
        while (points_todo.size() - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                push_track(1'b0);
            end else if (r < 75) begin
                push_track(1'b1);
            end else if (r < 90) begin
                push_point($urandom_range(0, CMAX), $urandom_range(0, CMAX));
            end else if (r < 95) begin
                push_point($urandom_range(0, 1) * CMAX, $urandom_range(0, 1) * CMAX);
            end else begin
                push_point(last_pt.x, last_pt.y);
            end
        end
    endtask

    task automatic wait_idle();
        while (points_todo.size() != 0 || i_s_tvalid || fits_due.size() != 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_point p;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!(i_s_tvalid && !o_s_tready)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (points_todo.size() != 0) begin
                p = points_todo.pop_front();
                i_s_tdata <= {{(IN_W - 2 * COORD_BITS){1'b0}}, p.y, p.x};
                i_s_tvalid <= 1'b1;
                gap_left = (steady || quiet) ? 0 : pick_idle();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // expectations from accepted beats
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            fits_due.push_back(predict_fit(i_s_tdata[COORD_BITS-1:0],
                                           i_s_tdata[2*COORD_BITS-1:COORD_BITS]));
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!steady && !quiet && $urandom_range(0, 3) == 0)
                stall_left = pick_idle();
        end
    end

    task automatic check_field(input string name, input logic [ICEPT_W-1:0] want,
                               input logic [ICEPT_W-1:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch expected %h actual %h", $realtime, name, want, got);
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_fit_rec e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (fits_due.size() == 0) begin
                err_count++;
                $display("%0t: unexpected beat expected none actual %h",
                         $realtime, o_m_tdata);
            end else begin
                e = fits_due.pop_front();
                check_field("slope_x", ICEPT_W'(e.slope_x),
                            ICEPT_W'(o_m_tdata[SX_LO +: SLOPE_W]));
                check_field("slope_y", ICEPT_W'(e.slope_y),
                            ICEPT_W'(o_m_tdata[SY_LO +: SLOPE_W]));
                check_field("icept_x", e.icept_x, o_m_tdata[IX_LO +: ICEPT_W]);
                check_field("icept_y", e.icept_y, o_m_tdata[IY_LO +: ICEPT_W]);
                check_field("monotonic", ICEPT_W'(e.mono), ICEPT_W'(o_m_tdata[MONO_BIT]));
            end
        end
    end

    // watchdog, plus the toggle for idle-free stretches
    always @(posedge i_clk) begin
        cycles++;
        if ($urandom_range(0, 299) == 0)
            quiet <= ~quiet;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int j;
        for (j = 0; j < DEPTH; j++) begin
            win[0][j] = '0;
            win[1][j] = '0;
        end
        fit_cnt = '0;
        last_pt.x = '0;
        last_pt.y = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, a repeated point, then full-scale rising and falling tracks
        push_point(CMAX, CMAX);
        push_point(0, 0);
        push_point(CMAX, 0);
        push_point(0, CMAX);
        push_point(0, CMAX);
        for (j = 0; j < DEPTH; j++)
            push_point(j * 292, j * 292);
        for (j = 1; j < DEPTH; j++)
            push_point(2044 - j * 292, 2044 - j * 292);
        push_point(100, 1000);
        push_point(50, 1500);
        push_point(1000, 10);
        wait_idle();

        queue_random(1000);
        wait_idle();

        // back-to-back stream with no idles on either side
        steady <= 1'b1;
        queue_random(450);
        wait_idle();
        steady <= 1'b0;

        queue_random(270);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fits_due.size() != 0) begin
            err_count++;
            $display("%0t: missing beats expected %0d actual 0", $realtime, fits_due.size());
        end
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
